// ----- design/fptw_pkg.sv -----
// Shared types and constants for the four-level page table walker.
// Depends on nothing; every other design file but fptw_ram imports it.
package fptw_pkg;

  localparam int unsigned VA_W              = 64;
  localparam int unsigned PA_W              = 52;
  localparam int unsigned FLAGS_W           = 12;
  localparam int unsigned ENTRY_W           = 52;
  localparam int unsigned INDEX_W           = 9;
  localparam int unsigned PAGE_W            = 12;
  localparam int unsigned ENTRIES_PER_FRAME = 512;

  // Flag patterns held in the low twelve bits of a table entry.
  localparam logic [PAGE_W-1:0] PAGE_MASK    = 12'hFFF;
  localparam logic [PAGE_W-1:0] PRESENT_FLAG = 12'h001;
  localparam logic [PAGE_W-1:0] LINK_FLAGS   = 12'h007;

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
  localparam logic [1:0] ST_NO_FRAME   = 2'd2;

  typedef enum logic {
    OP_MAP       = 1'b0,
    OP_TRANSLATE = 1'b1
  } fptw_op_e;

  typedef struct packed {
    fptw_op_e            operation;
    logic [VA_W-1:0]     virtual_address;
    logic [PA_W-1:0]     physical_address;
    logic [FLAGS_W-1:0]  map_flags;
  } fptw_req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [VA_W-1:0] translated_address;
  } fptw_res_t;

  // Source of the address returned with a result.
  typedef enum logic [1:0] {
    ASEL_ZERO,
    ASEL_WINDOW,
    ASEL_LEAF
  } fptw_asel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       clear_step;
    logic       win_calc;
    logic       walk_rd;
    logic       walk_adv;
    logic       alloc;
    logic       leaf_wr;
    logic       fin;
    logic [1:0] fin_status;
    fptw_asel_e fin_asel;
    logic       out_load;
  } fptw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic is_translate;
    logic win_hit;
    logic present;
    logic frames_left;
    logic leaf_level;
    logic last_table;
  } fptw_sts_t;

endpackage

// ----- design/four_level_page_table_map_walk.sv -----
// Top level of the four-level page table walker: configuration registers,
// controller and datapath. Depends on fptw_pkg, fptw_ctrl and fptw_dp.
//
//   Channel  Direction  Handshake                Payload
//   request  in         req_valid_i/req_ready_o  req_i (fptw_req_t)
//   result   out        res_valid_o/res_ready_i  res_o (fptw_res_t)
//   config   in         APB psel/penable/pready  paddr, pwdata, prdata
//
// After reset the table store is swept to zero, one entry a cycle, over
// all TABLE_FRAMES * 512 entries (8192 at the default) before the first
// request is taken; configuration writes are accepted throughout.
// A request is handled one at a time. Each table level is a read of the
// store's single read port and then a check. A map walks three levels,
// writes the leaf entry and loads the result; a translate first tests the
// direct-map window and, unless it hits, walks up to four levels.
// A result waits in an output register; the next request is taken while it
// waits, and its own result is held back until that register is free.
module four_level_page_table_map_walk #(
  parameter int unsigned TABLE_FRAMES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  fptw_pkg::fptw_req_t req_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output fptw_pkg::fptw_res_t res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  import fptw_pkg::*;

  // Register indexes; each 64-bit register takes an eight-byte slot.
  localparam logic REG_DM_OFFSET = 1'b0;
  localparam logic REG_DM_SIZE   = 1'b1;

  logic [VA_W-1:0] dm_offset_q;
  logic [VA_W-1:0] dm_size_q;
  logic            cfg_wr;
  fptw_cmd_t       cmd;
  fptw_sts_t       sts;

  // The port never stalls, so a write lands at the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dm_offset_q <= '0;
      dm_size_q   <= '0;
    end else if (cfg_wr) begin
      case (paddr[3])
        REG_DM_OFFSET: dm_offset_q <= pwdata;
        REG_DM_SIZE:   dm_size_q   <= pwdata;
        default:       dm_offset_q <= dm_offset_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_DM_OFFSET: prdata = dm_offset_q;
      REG_DM_SIZE:   prdata = dm_size_q;
      default:       prdata = '0;
    endcase
  end

  // The controller sequences the walk; the datapath owns the table store and the walk and result registers.
  fptw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fptw_dp #(
    .TABLE_FRAMES (TABLE_FRAMES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .dm_offset_i (dm_offset_q),
    .dm_size_i   (dm_size_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o)
  );

endmodule

// ----- design/fptw_ram.sv -----
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
module fptw_ram #(
  parameter int unsigned WIDTH = 52,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/fptw_ctrl.sv -----
// Controller state machine of the page table walker.
// Depends on fptw_pkg for the command and status structs.
module fptw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  input  fptw_pkg::fptw_sts_t sts_i,
  output fptw_pkg::fptw_cmd_t cmd_o
);
  import fptw_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WIN_SUB,
    S_WIN_CMP,
    S_READ,
    S_CHECK,
    S_LEAF,
    S_DONE
  } state_e;

  state_e    state_q, state_d;
  logic      out_valid_q;
  logic      out_free;
  fptw_cmd_t cmd;

  assign out_free = !out_valid_q || res_ready_i;

  always_comb begin
    cmd            = '0;
    cmd.fin_status = ST_OK;
    cmd.fin_asel   = ASEL_ZERO;
    state_d        = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd.capture = 1'b1;
          state_d     = S_READ;
        end
      end
      S_WIN_SUB: begin
        cmd.win_calc = 1'b1;
        state_d      = S_WIN_CMP;
      end
      S_WIN_CMP: begin
        if (sts_i.win_hit) begin
          cmd.fin      = 1'b1;
          cmd.fin_asel = ASEL_WINDOW;
          state_d      = S_DONE;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd.walk_rd = 1'b1;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.is_translate) begin
          if (!sts_i.present) begin
            cmd.fin        = 1'b1;
            cmd.fin_status = ST_NOT_MAPPED;
            state_d        = S_DONE;
          end else if (sts_i.leaf_level) begin
            cmd.fin      = 1'b1;
            cmd.fin_asel = ASEL_LEAF;
            state_d      = S_DONE;
          end else begin
            cmd.walk_adv = 1'b1;
            state_d      = S_READ;
          end
        end else if (sts_i.present || sts_i.frames_left) begin
          cmd.walk_adv = sts_i.present;
          cmd.alloc    = !sts_i.present;
          state_d      = sts_i.last_table ? S_LEAF : S_READ;
        end else begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ST_NO_FRAME;
          state_d        = S_DONE;
        end
      end
      S_LEAF: begin
        cmd.leaf_wr = 1'b1;
        cmd.fin     = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // A translate request tests the direct-map window before walking.
    if (cmd.capture && sts_i.is_translate) begin
      state_d = S_WIN_SUB;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd.out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// ----- design/fptw_dp.sv -----
// Datapath of the page table walker: request register, walk registers,
// frame counter, window arithmetic, result registers and the table store.
// Depends on fptw_pkg and fptw_ram.
module fptw_dp #(
  parameter int unsigned TABLE_FRAMES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fptw_pkg::fptw_req_t        req_i,
  input  logic [fptw_pkg::VA_W-1:0]  dm_offset_i,
  input  logic [fptw_pkg::VA_W-1:0]  dm_size_i,
  input  fptw_pkg::fptw_cmd_t        cmd_i,
  output fptw_pkg::fptw_sts_t        sts_o,
  output fptw_pkg::fptw_res_t        res_o
);
  import fptw_pkg::*;

  localparam int unsigned FRAME_W = $clog2(TABLE_FRAMES);
  localparam int unsigned CNT_W   = $clog2(TABLE_FRAMES + 1);
  localparam int unsigned DEPTH   = TABLE_FRAMES * ENTRIES_PER_FRAME;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] CLR_LAST   = ADDR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  FRAMES_END = CNT_W'(TABLE_FRAMES);

  fptw_req_t          req_q;
  logic [FRAME_W-1:0] frame_q;
  logic [1:0]         level_q;
  logic [CNT_W-1:0]   free_q;
  logic [ADDR_W-1:0]  clr_q;
  logic [VA_W-1:0]    diff_q;
  logic               borrow_q;
  fptw_res_t          rslt_q;
  fptw_res_t          res_q;

  logic [INDEX_W-1:0] idx;
  logic [ADDR_W-1:0]  walk_addr;
  logic [ENTRY_W-1:0] rd_entry;
  logic [ENTRY_W-1:0] link_entry;
  logic [ENTRY_W-1:0] leaf_entry;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [VA_W:0]      win_diff;
  logic [VA_W-1:0]    fin_addr;

  // Nine-bit table index for the current level, from the top level down.
  always_comb begin
    case (level_q)
      2'd0:    idx = req_q.virtual_address[47:39];
      2'd1:    idx = req_q.virtual_address[38:30];
      2'd2:    idx = req_q.virtual_address[29:21];
      default: idx = req_q.virtual_address[20:12];
    endcase
  end

  assign walk_addr  = ADDR_W'({frame_q, idx});
  assign link_entry = ENTRY_W'({free_q[FRAME_W-1:0], LINK_FLAGS});
  assign leaf_entry = {req_q.physical_address[PA_W-1:PAGE_W],
                       (req_q.map_flags & PAGE_MASK) | PRESENT_FLAG};

  assign ram_we    = cmd_i.clear_step || cmd_i.alloc || cmd_i.leaf_wr;
  assign ram_waddr = cmd_i.clear_step ? clr_q : walk_addr;
  assign ram_wdata = cmd_i.clear_step ? '0 : (cmd_i.alloc ? link_entry : leaf_entry);

  fptw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.walk_rd),
    .raddr_i (walk_addr),
    .rdata_o (rd_entry)
  );

  assign win_diff = {1'b0, req_q.virtual_address} - {1'b0, dm_offset_i};

  always_comb begin
    case (cmd_i.fin_asel)
      ASEL_WINDOW: fin_addr = diff_q;
      ASEL_LEAF:   fin_addr = VA_W'({rd_entry[ENTRY_W-1:PAGE_W],
                                     req_q.virtual_address[PAGE_W-1:0]});
      default:     fin_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 2'd0;
      free_q  <= CNT_W'(1);
      clr_q   <= '0;
    end else begin
      if (cmd_i.clear_step) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (cmd_i.capture) begin
        level_q <= 2'd0;
      end else if (cmd_i.walk_adv || cmd_i.alloc) begin
        level_q <= level_q + 2'd1;
      end
      if (cmd_i.alloc) begin
        free_q <= free_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= req_i;
      frame_q <= '0;
    end else if (cmd_i.walk_adv) begin
      frame_q <= rd_entry[PAGE_W +: FRAME_W];
    end else if (cmd_i.alloc) begin
      frame_q <= free_q[FRAME_W-1:0];
    end
    if (cmd_i.win_calc) begin
      {borrow_q, diff_q} <= win_diff;
    end
    if (cmd_i.fin) begin
      rslt_q.status             <= cmd_i.fin_status;
      rslt_q.translated_address <= fin_addr;
    end
    if (cmd_i.out_load) begin
      res_q <= rslt_q;
    end
  end

  assign sts_o.clear_last   = (clr_q == CLR_LAST);
  assign sts_o.is_translate = cmd_i.capture ? (req_i.operation == OP_TRANSLATE)
                                            : (req_q.operation == OP_TRANSLATE);
  assign sts_o.win_hit      = !borrow_q && (diff_q <= dm_size_i);
  assign sts_o.present      = rd_entry[0];
  assign sts_o.frames_left  = (free_q < FRAMES_END);
  assign sts_o.leaf_level   = (level_q == 2'd3);
  assign sts_o.last_table   = (level_q == 2'd2);

  assign res_o = res_q;

endmodule
